// ----- rtl/core/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared sizes for the RC4 byte cipher: key store depth and counter widths.
// ----------------------------------------------------------------------------
package rc4_pkg;

   // Longest key that is kept; further key bytes are dropped
   localparam int MAX_KEY_BYTES = 256;

   // Key count holds 0 .. MAX_KEY_BYTES inclusive
   localparam int KEY_CNT_W = $clog2(MAX_KEY_BYTES + 1);

   // Index into the key store
   localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   // Size of the permutation
   localparam int PERM_DEPTH = 256;

   typedef logic [7:0] byte_type;

endpackage

// ----- rtl/core/rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte cipher built round one single-port 256-byte permutation memory
// and a small sequencer that drives that one port at every step.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_type, req_key_byte,
//          |           |                       | req_key_last, req_data_byte
//  rsp     | out       | rsp_valid / rsp_ready | rsp_out_byte
//
//  A data item passes through the states D_J, D_WI, D_WJ, D_RT and D_OUT
//  before its result reaches the output register, and no new item is taken
//  until it does: three dependent reads and two swap writes share the single
//  port of the permutation memory. A key byte is stored as it is taken; a
//  final key byte adds the key schedule, K_RD, K_J, K_WI, K_WJ in each of 256 rounds.
//  Reset restores the identity permutation at once through per-entry valid
//  bits; a final key byte clears them the same way. A result waiting in the
//  output register does not block the next item; a second result waits for it.
//
module rc4_stream_cipher
   import rc4_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_type,
   input  logic [7:0]     req_key_byte,
   input  logic           req_key_last,
   input  logic [7:0]     req_data_byte,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [7:0]     rsp_out_byte
);

   // Sequencer codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_D_J  = 4'd1;
   localparam logic [3:0] ST_D_WI = 4'd2;
   localparam logic [3:0] ST_D_WJ = 4'd3;
   localparam logic [3:0] ST_D_RT = 4'd4;
   localparam logic [3:0] ST_D_OUT = 4'd5;
   localparam logic [3:0] ST_K_RD = 4'd6;
   localparam logic [3:0] ST_K_J  = 4'd7;
   localparam logic [3:0] ST_K_WI = 4'd8;
   localparam logic [3:0] ST_K_WJ = 4'd9;

   localparam logic [KEY_CNT_W-1:0] KEY_MAX = KEY_CNT_W'(MAX_KEY_BYTES);
   localparam logic [7:0]           LAST_ROUND = 8'(PERM_DEPTH - 1);

   // Control state
   logic [3:0]           state_ff, state_in;
   logic [KEY_CNT_W-1:0] key_count_ff, key_count_in;
   logic [KEY_CNT_W-1:0] key_len_ff, key_len_in;
   logic [KEY_IDX_W-1:0] kidx_ff, kidx_in;
   byte_type             ia_ff, ia_in;
   byte_type             ib_ff, ib_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers
   byte_type             si_ff, si_in;
   byte_type             sj_ff, sj_in;
   byte_type             data_ff, data_in;
   byte_type             rsp_out_byte_ff, rsp_out_byte_in;

   // Permutation memory and its valid bits
   byte_type             perm_mem [PERM_DEPTH];
   logic [PERM_DEPTH-1:0] perm_valid_ff;
   byte_type             perm_addr;
   byte_type             perm_wdata;
   logic                 perm_we;
   logic                 perm_clr;
   byte_type             pm_q;
   byte_type             pa_q;
   logic                 pv_q;
   byte_type             perm_rd;

   // Key store
   byte_type             key_mem [MAX_KEY_BYTES];
   byte_type             key_q;
   logic                 key_we;

   logic                 req_take;
   logic                 out_free;
   logic [KEY_CNT_W-1:0] key_count_next;
   logic [KEY_CNT_W-1:0] kidx_next;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_take     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // An entry never written since the last clear reads as its own index
   assign perm_rd = pv_q ? pm_q : pa_q;

   // Saturating key count after storing this key byte
   assign key_count_next = (key_count_ff < KEY_MAX) ? key_count_ff + 1'b1 : key_count_ff;
   assign key_we         = req_take && !req_type && (key_count_ff < KEY_MAX);

   // Key position for the next schedule round, repeating over the key length
   assign kidx_next = KEY_CNT_W'(kidx_ff) + 1'b1;

   // Drive the single memory port from the sequencer
   always_comb begin
      perm_addr  = ia_ff;
      perm_we    = 1'b0;
      perm_wdata = perm_rd;
      unique case (state_ff)
         ST_IDLE: begin
            perm_addr = ia_ff + 8'd1;
         end
         ST_D_J: begin
            perm_addr = ib_ff + perm_rd;
         end
         ST_D_WI, ST_K_WI: begin
            perm_addr  = ia_ff;
            perm_we    = 1'b1;
            perm_wdata = perm_rd;
         end
         ST_D_WJ, ST_K_WJ: begin
            perm_addr  = ib_ff;
            perm_we    = 1'b1;
            perm_wdata = si_ff;
         end
         ST_D_RT, ST_D_OUT: begin
            perm_addr = si_ff + sj_ff;
         end
         ST_K_RD: begin
            perm_addr = ia_ff;
         end
         ST_K_J: begin
            perm_addr = ib_ff + perm_rd + key_q;
         end
         default: begin
            perm_addr = ia_ff;
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in        = state_ff;
      key_count_in    = key_count_ff;
      key_len_in      = key_len_ff;
      kidx_in         = kidx_ff;
      ia_in           = ia_ff;
      ib_in           = ib_ff;
      si_in           = si_ff;
      sj_in           = sj_ff;
      data_in         = data_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      perm_clr        = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_type) begin
               // Step the first index and fetch its entry
               ia_in    = perm_addr;
               data_in  = req_data_byte;
               state_in = ST_D_J;
            end else if (req_take) begin
               if (req_key_last) begin
                  // Restart from the identity permutation
                  key_len_in   = key_count_next;
                  key_count_in = '0;
                  kidx_in      = '0;
                  ia_in        = '0;
                  ib_in        = '0;
                  perm_clr     = 1'b1;
                  state_in     = ST_K_RD;
               end else begin
                  key_count_in = key_count_next;
               end
            end
         end
         ST_D_J: begin
            si_in    = perm_rd;
            ib_in    = perm_addr;
            state_in = ST_D_WI;
         end
         ST_D_WI: begin
            sj_in    = perm_rd;
            state_in = ST_D_WJ;
         end
         ST_D_WJ: begin
            state_in = ST_D_RT;
         end
         ST_D_RT: begin
            state_in = ST_D_OUT;
         end
         ST_D_OUT: begin
            // Hold the keystream read until the output register is free
            if (out_free) begin
               rsp_out_byte_in = data_ff ^ perm_rd;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_K_RD: begin
            state_in = ST_K_J;
         end
         ST_K_J: begin
            si_in    = perm_rd;
            ib_in    = perm_addr;
            state_in = ST_K_WI;
         end
         ST_K_WI: begin
            state_in = ST_K_WJ;
         end
         ST_K_WJ: begin
            // Advance the round and the key position
            ia_in   = ia_ff + 8'd1;
            kidx_in = (kidx_next >= key_len_ff) ? '0 : kidx_next[KEY_IDX_W-1:0];
            if (ia_ff == LAST_ROUND) begin
               ib_in    = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_K_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         key_len_ff   <= '0;
         kidx_ff      <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         key_len_ff   <= key_len_in;
         kidx_ff      <= kidx_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      si_ff           <= si_in;
      sj_ff           <= sj_in;
      data_ff         <= data_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
   end

   // Permutation valid bits: clear on reset and at each new key
   always_ff @(posedge clock) begin
      if (reset) begin
         perm_valid_ff <= '0;
      end else if (perm_clr) begin
         perm_valid_ff <= '0;
      end else if (perm_we) begin
         perm_valid_ff[perm_addr] <= 1'b1;
      end
   end

   // Permutation memory, registered read
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_addr] <= perm_wdata;
      end
      pm_q <= perm_mem[perm_addr];
      pa_q <= perm_addr;
      pv_q <= perm_valid_ff[perm_addr];
   end

   // Key store, registered read at the schedule's key position
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_count_ff[KEY_IDX_W-1:0]] <= req_key_byte;
      end
      key_q <= key_mem[kidx_ff];
   end

   // A final key byte restores the identity permutation on the next cycle
   a_key_restart: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_type && req_key_last |=> perm_valid_ff == '0)
      else $error("permutation not cleared at key restart");

   // Leaving the schedule leaves both indices at zero
   a_sched_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_K_WJ && ia_ff == LAST_ROUND |=> ia_ff == '0 && ib_ff == '0)
      else $error("indices not cleared after key schedule");

   // A data item finishes without reopening the input channel early
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input taken while a data item is in flight");

   // The key count never passes the store depth
   a_key_count: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KEY_MAX && key_len_ff <= KEY_MAX)
      else $error("key count beyond store depth");

endmodule
